// ===== src/slcan_rm_pkg.sv =====
// Shared types and constants for the SLCAN response matcher.
// Used by the channel interfaces and the top level; depends on nothing.
package slcan_rm_pkg;

  // Character codes the line parser looks for.
  localparam logic [7:0] CHAR_T    = 8'h74;  // 't'
  localparam logic [7:0] CHAR_CR   = 8'h0D;  // carriage return
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'

  // Line layout: 't', three id digits, one length digit, then data digits.
  localparam int unsigned HDR_LEN        = 5;
  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned POS_W          = 5;
  localparam logic [POS_W-1:0] POS_MAX   = '1;

  // Configuration register byte addresses.
  localparam logic [2:0] REG_RESPONSE_ID      = 3'd0;
  localparam logic [2:0] REG_RESPONSE_COMMAND = 3'd4;

  // One received character.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       clear_line;
  } in_word_t;

  // One parsed line.
  typedef struct packed {
    logic        frame_ok;
    logic        matched;
    logic [11:0] frame_id;
    logic [3:0]  data_len;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
  } out_word_t;

endpackage

// ===== src/slcan_rm_if.sv =====
// Valid/ready channel interfaces for the SLCAN response matcher.
// Depends on slcan_rm_pkg for the word types.
interface slcan_rm_in_if;
  logic                  valid;
  logic                  ready;
  slcan_rm_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slcan_rm_out_if;
  logic                   valid;
  logic                   ready;
  slcan_rm_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/slcan_response_matcher.sv =====
// SLCAN line parser: gathers received characters into lines and reports
// each carriage-return-terminated line as a parsed frame with a match flag.
// Depends on slcan_rm_pkg and the channel interfaces in slcan_rm_if.sv.
//
//   channel | direction | content
//   --------+-----------+---------------------------------------------
//   rx      | in        | one character word: rx_byte, clear_line
//   res     | out       | one frame word per carriage return
//   APB     | in        | response_id at 0x0, response_command at 0x4
//
// The line state updates at the accepting edge of a character, and a
// frame word lands in the output register at that same edge.
// A new character is taken every cycle while the output register is empty
// or being drained, so throughput is one character per clock.
// Characters that end no line give no word. Reset (rst, synchronous) clears
// both registers, out_valid and the line state but for the data bytes.
module slcan_response_matcher (
  input  logic                 clk,
  input  logic                 rst,
  slcan_rm_in_if.sink          rx,
  slcan_rm_out_if.source       res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Configuration registers.
  logic [11:0] response_id;
  logic [7:0]  response_command;

  // Line state.
  logic [slcan_rm_pkg::POS_W-1:0] line_position;
  logic                           line_bad;
  logic [11:0]                    id_accumulator;
  logic [3:0]                     length_held;
  logic [3:0]                     high_nibble;
  logic [7:0]                     data_store [8];

  // Output register.
  logic                    out_valid;
  slcan_rm_pkg::out_word_t out_word;

  logic accept;
  logic is_cr;

  // Hex digit decode: bit 4 flags a legal digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // APB access: always ready, register chosen by address bit 2.
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      slcan_rm_pkg::REG_RESPONSE_ID[2]: prdata = {20'd0, response_id};
      default:                          prdata = {24'd0, response_command};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_id      <= 12'd0;
      response_command <= 8'd0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == slcan_rm_pkg::REG_RESPONSE_COMMAND[2]) begin
        response_command <= pwdata[7:0];
      end else begin
        response_id <= pwdata[11:0];
      end
    end
  end

  // Handshake: take a word whenever the output register is free or draining.
  assign rx.ready  = !out_valid || res.ready;
  assign accept    = rx.valid && rx.ready;
  assign is_cr     = (rx.data.rx_byte == slcan_rm_pkg::CHAR_CR);
  assign res.valid = out_valid;
  assign res.data  = out_word;

  // Per-character decode against the line state as seen after a clear.
  logic [slcan_rm_pkg::POS_W-1:0] pos_eff;
  logic                           bad_eff;
  logic [4:0]                     hex;
  logic [slcan_rm_pkg::POS_W-1:0] data_off;
  logic [5:0]                     data_end;
  logic                           len_digit_ok;
  logic                           bad_hit;
  logic                           frame_ok;
  logic [7:0]                     bytes_out [8];
  slcan_rm_pkg::out_word_t        word_next;

  always_comb begin
    pos_eff  = rx.data.clear_line ? '0 : line_position;
    bad_eff  = rx.data.clear_line ? 1'b0 : line_bad;
    hex      = hex_decode(rx.data.rx_byte);
    data_off = pos_eff - slcan_rm_pkg::POS_W'(slcan_rm_pkg::HDR_LEN);
    data_end = 6'(slcan_rm_pkg::HDR_LEN) + {1'b0, length_held, 1'b0};
    len_digit_ok = (rx.data.rx_byte >= slcan_rm_pkg::CHAR_ZERO) &&
                   (rx.data.rx_byte <= slcan_rm_pkg::CHAR_ZERO +
                                       8'(slcan_rm_pkg::MAX_DATA_BYTES));
    // The character fails the check that its place in the line calls for.
    if (bad_eff) begin
      bad_hit = 1'b0;
    end else if (pos_eff == '0) begin
      bad_hit = (rx.data.rx_byte != slcan_rm_pkg::CHAR_T);
    end else if (pos_eff < 5'd4) begin
      bad_hit = !hex[4];
    end else if (pos_eff == 5'd4) begin
      bad_hit = !len_digit_ok;
    end else if ({1'b0, pos_eff} < data_end) begin
      bad_hit = !hex[4];
    end else begin
      bad_hit = 1'b0;
    end
  end

  // Frame word built from the line state at a carriage return.
  always_comb begin
    frame_ok = !bad_eff &&
               ({1'b0, pos_eff} >= 6'(slcan_rm_pkg::HDR_LEN)) &&
               ({1'b0, pos_eff} >= data_end);
    for (int i = 0; i < 8; i++) begin
      bytes_out[i] = (frame_ok && (4'(i) < length_held)) ? data_store[i] : 8'd0;
    end
    word_next.frame_ok = frame_ok;
    word_next.matched  = frame_ok && (id_accumulator == response_id) &&
                         (length_held != 4'd0) && (data_store[0] == response_command);
    word_next.frame_id = frame_ok ? id_accumulator : 12'd0;
    word_next.data_len = frame_ok ? length_held : 4'd0;
    word_next.byte0    = bytes_out[0];
    word_next.byte1    = bytes_out[1];
    word_next.byte2    = bytes_out[2];
    word_next.byte3    = bytes_out[3];
    word_next.byte4    = bytes_out[4];
    word_next.byte5    = bytes_out[5];
    word_next.byte6    = bytes_out[6];
    word_next.byte7    = bytes_out[7];
  end

  // Line state update. A carriage return closes the line; any other
  // character advances the position and is checked by its place in the line.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position  <= '0;
      line_bad       <= 1'b0;
      id_accumulator <= 12'd0;
      length_held    <= 4'd0;
      high_nibble    <= 4'd0;
    end else if (accept) begin
      if (is_cr) begin
        line_position  <= '0;
        line_bad       <= 1'b0;
        id_accumulator <= 12'd0;
        length_held    <= 4'd0;
      end else begin
        line_position <= (pos_eff < slcan_rm_pkg::POS_MAX) ? pos_eff + 1'b1 : pos_eff;
        line_bad      <= bad_eff || bad_hit;
        if (rx.data.clear_line) begin
          id_accumulator <= 12'd0;
          length_held    <= 4'd0;
        end
        if (!bad_eff && !bad_hit) begin
          if ((pos_eff != '0) && (pos_eff < 5'd4)) begin
            id_accumulator <= {(rx.data.clear_line ? 8'd0 : id_accumulator[7:0]),
                               hex[3:0]};
          end else if (pos_eff == 5'd4) begin
            length_held <= rx.data.rx_byte[3:0];
          end else if ((pos_eff > 5'd4) && ({1'b0, pos_eff} < data_end) &&
                       !data_off[0]) begin
            high_nibble <= hex[3:0];
          end
        end
      end
    end
  end

  // Data bytes: the second digit of a pair completes the byte.
  always_ff @(posedge clk) begin
    if (accept && !is_cr && !bad_eff && (pos_eff > 5'd4) &&
        ({1'b0, pos_eff} < data_end) && hex[4] && data_off[0]) begin
      data_store[data_off[3:1]] <= {high_nibble, hex[3:0]};
    end
  end

  // Output register: loaded by a carriage return, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= is_cr;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_cr) begin
      out_word <= word_next;
    end
  end

`ifndef SYNTH
  // A match is only ever reported on a well-formed frame.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_word.matched || out_word.frame_ok))
    else $error("match flagged on a bad frame");

  // A bad frame carries no id, length or first byte.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.frame_ok) |->
      (out_word.frame_id == 12'd0 && out_word.data_len == 4'd0 &&
       out_word.byte0 == 8'd0))
    else $error("bad frame carries payload");

  // Length never exceeds the data byte limit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.data_len <= 4'(slcan_rm_pkg::MAX_DATA_BYTES)))
    else $error("length above limit");

  // A carriage return yields a word and restarts the line.
  assert property (@(posedge clk) disable iff (rst)
    (accept && is_cr) |=> (out_valid && line_position == '0 && !line_bad))
    else $error("carriage return not handled");
`endif

endmodule

// ===== bench/slcan_rm_checker.sv =====
// Checker for the SLCAN response matcher: watches both channels and the APB
// port, predicts the frame word for each carriage return and compares.
// Depends on slcan_rm_pkg and the channel interfaces in slcan_rm_if.sv.
module slcan_rm_checker
  import slcan_rm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  slcan_rm_in_if      rx,
  slcan_rm_out_if     res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  // Our own copy of the two registers.
  logic [11:0] want_id;
  logic [7:0]  want_cmd;

  // Line state of the parser as we predict it.
  logic [4:0]  line_pos;
  logic        line_bad;
  logic [11:0] id_acc;
  logic [3:0]  len_held;
  logic [3:0]  hi_nib;
  logic [7:0]  data_bytes [8];

  // Frame words still owed by the block, oldest first.
  out_word_t frames_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Returns {is_hex, value}; only 0-9, A-F and a-f count as digits.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
    return 5'b0;
  endfunction

  task automatic wipe_line;
    line_pos = '0;
    line_bad = 1'b0;
    id_acc   = '0;
    len_held = '0;
    hi_nib   = '0;
    foreach (data_bytes[j]) data_bytes[j] = '0;
  endtask

  // One character of a line; the position saturates and bad lines stay bad.
  task automatic take_char(input logic [7:0] c);
    logic [4:0] p;
    logic [4:0] h;
    int off;
    p = line_pos;
    h = hex_digit(c);
    off = int'(p) - int'(HDR_LEN);
    if (line_pos != POS_MAX) line_pos = line_pos + 5'd1;
    if (!line_bad) begin
      if (p == 0) begin
        if (c != CHAR_T) line_bad = 1'b1;
      end else if (p < 4) begin
        if (!h[4]) line_bad = 1'b1;
        else id_acc = {id_acc[7:0], h[3:0]};
      end else if (p == 4) begin
        if (c < CHAR_ZERO || c > CHAR_ZERO + MAX_DATA_BYTES) line_bad = 1'b1;
        else len_held = 4'(c - CHAR_ZERO);
      end else if (off < 2 * int'(len_held)) begin
        if (!h[4]) line_bad = 1'b1;
        else if (off % 2 == 0) hi_nib = h[3:0];
        else data_bytes[off / 2] = {hi_nib, h[3:0]};
      end
    end
  endtask

  // Carriage return: build the frame word for the line gathered so far.
  function automatic out_word_t finish_line();
    out_word_t w;
    logic [7:0] shown [8];
    bit ok;
    w = '0;
    ok = !line_bad && line_pos >= HDR_LEN && line_pos >= HDR_LEN + 2 * len_held;
    foreach (shown[j]) shown[j] = (ok && j < len_held) ? data_bytes[j] : 8'h00;
    if (ok) begin
      w.frame_ok = 1'b1;
      w.frame_id = id_acc;
      w.data_len = len_held;
      w.matched  = (id_acc == want_id) && (len_held != 0) && (data_bytes[0] == want_cmd);
    end
    {w.byte0, w.byte1, w.byte2, w.byte3, w.byte4, w.byte5, w.byte6, w.byte7} =
      {shown[0], shown[1], shown[2], shown[3], shown[4], shown[5], shown[6], shown[7]};
    return w;
  endfunction

  task automatic check_field(input string name, input logic [11:0] want,
                             input logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Everything happens at the rising edge, on values settled before it.
  always @(posedge clk) begin
    out_word_t w;
    out_word_t got;
    if (rst) begin
      want_id  = '0;
      want_cmd = '0;
      wipe_line();
      frames_due.delete();
    end else begin
      // Register writes on the access phase.
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_RESPONSE_ID) want_id = pwdata[11:0];
        else if (paddr == REG_RESPONSE_COMMAND) want_cmd = pwdata[7:0];
      end

      // An outgoing frame word is checked against the oldest prediction.
      if (res.valid && res.ready) begin
        got = res.data;
        if (frames_due.size() == 0) begin
          $error("frame word arrived with none predicted (id 0x%0h)", got.frame_id);
          fail_count++;
        end else begin
          w = frames_due.pop_front();
          check_field("frame_ok", w.frame_ok, got.frame_ok);
          check_field("matched", w.matched, got.matched);
          check_field("frame_id", w.frame_id, got.frame_id);
          check_field("data_len", w.data_len, got.data_len);
          check_field("byte0", w.byte0, got.byte0);
          check_field("byte1", w.byte1, got.byte1);
          check_field("byte2", w.byte2, got.byte2);
          check_field("byte3", w.byte3, got.byte3);
          check_field("byte4", w.byte4, got.byte4);
          check_field("byte5", w.byte5, got.byte5);
          check_field("byte6", w.byte6, got.byte6);
          check_field("byte7", w.byte7, got.byte7);
        end
      end

      // An accepted character word updates the line; a return yields a frame.
      if (rx.valid && rx.ready) begin
        if (rx.data.clear_line) wipe_line();
        if (rx.data.rx_byte != CHAR_CR) begin
          take_char(rx.data.rx_byte);
        end else begin
          frames_due.push_back(finish_line());
          wipe_line();
        end
      end
    end
    pending = frames_due.size();
  end

endmodule

// ===== bench/slcan_response_matcher_tb.sv =====
// Testbench top for the SLCAN response matcher: drives character words and
// register writes, stalls the result side, and reports the verdict.
// Depends on slcan_rm_pkg, slcan_rm_if.sv, the block and slcan_rm_checker.
module slcan_response_matcher_tb;
  import slcan_rm_pkg::*;

  localparam int SETTLE     = 4;
  localparam int RAND_CHARS = 850;
  localparam int PHASES     = 4;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  // When set, neither side inserts idle cycles.
  bit calm = 1'b0;

  // Register values as last written, used to aim frames at a match.
  logic [11:0] stim_id  = '0;
  logic [7:0]  stim_cmd = '0;

  // Characters of the line being sent.
  logic [7:0] line_q [$];
  int sent_chars = 0;

  slcan_rm_in_if  rx_ch ();
  slcan_rm_out_if res_ch ();

  slcan_response_matcher uut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slcan_rm_checker chk (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side stalls at random except in calm stretches.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("slcan_response_matcher_tb NOT OK");
    $finish;
  end

  // Hex digit with random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return CHAR_ZERO + 8'(n);
    return (($urandom_range(1) != 0) ? "A" : "a") + 8'(n - 10);
  endfunction

  function automatic logic [7:0] any_but_cr();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CHAR_CR) b = 8'hF2;
    return b;
  endfunction

  // Characters a lenient parser would let through but this one must reject; the default case is any byte but a return.
  function automatic logic [7:0] bad_char();
    case ($urandom_range(9))
      0: return " ";
      1: return "+";
      2: return "-";
      3: return "x";
      4: return "g";
      5: return "G";
      6: return ":";
      7: return "@";
      default: return any_but_cr();
    endcase
  endfunction

  function automatic logic [7:0] data_value();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Sends one character word; called and returns just after a falling edge.
  task automatic put_char(input logic [7:0] ch, input bit clr);
    while (!calm && $urandom_range(99) < 14) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.data  <= {ch, clr};
    do @(posedge clk); while (!rx_ch.ready);
    @(negedge clk);
    sent_chars++;
  endtask

  task automatic send_text(input string s, input bit clr_on_cr);
    for (int i = 0; i < s.len(); i++) put_char(s[i], 1'b0);
    put_char(CHAR_CR, clr_on_cr);
  endtask

  // Waits until every predicted frame word has come out, then waits out SETTLE.
  task automatic drain;
    rx_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Setup and access phases, then drops psel and idles before the next transfer.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_registers(input logic [11:0] id, input logic [7:0] cmd);
    apb_write(REG_RESPONSE_ID, {20'b0, id});
    apb_write(REG_RESPONSE_COMMAND, {24'b0, cmd});
    stim_id  = id;
    stim_cmd = cmd;
  endtask

  // Well-formed frame without the return; a match frame carries the
  // configured id and command.
  task automatic make_frame(input bit aim);
    logic [11:0] id;
    int len;
    logic [7:0] db;
    id  = aim ? stim_id : 12'($urandom);
    len = aim ? $urandom_range(8, 1) : $urandom_range(8, 0);
    line_q = {};
    line_q.push_back(CHAR_T);
    for (int i = 2; i >= 0; i--) line_q.push_back(hex_char(id[4*i +: 4]));
    line_q.push_back(CHAR_ZERO + 8'(len));
    for (int i = 0; i < len; i++) begin
      db = (aim && i == 0) ? stim_cmd : data_value();
      line_q.push_back(hex_char(db[7:4]));
      line_q.push_back(hex_char(db[3:0]));
    end
  endtask

  // One random line: mostly good frames, some broken, some plain noise.
  task automatic send_random_line;
    int kind;
    int n;
    kind = $urandom_range(99);
    make_frame($urandom_range(99) < 40);
    if (kind < 25) begin
      // Trailing characters, often far past the saturation point.
      n = $urandom_range(30, 1);
      repeat (n) line_q.push_back(any_but_cr());
    end else if (kind >= 60 && kind < 75) begin
      line_q[$urandom_range(line_q.size() - 1)] = bad_char();
    end else if (kind >= 75 && kind < 87) begin
      n = $urandom_range(line_q.size() - 1);
      while (line_q.size() > n) void'(line_q.pop_back());
    end else if (kind >= 87) begin
      line_q = {};
      n = $urandom_range(40);
      repeat (n) line_q.push_back(any_but_cr());
    end
    line_q.push_back(CHAR_CR);
    foreach (line_q[i]) put_char(line_q[i], $urandom_range(99) < 3);
  endtask

  initial begin
    int base;
    int lines;
    int guard;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rx_ch.valid    = 1'b0;
    rx_ch.data     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines with the registers at their reset values.
    send_text("", 1'b0);        // empty line
    send_text("t0000", 1'b0);   // lowest id, no data
    send_text("t12", 1'b1);     // clear arriving with the return
    send_text("t7a92A", 1'b0);  // line ends before the second data digit
    send_text("tFfF9", 1'b0);   // highest id, length digit out of range
    drain();

    // Random lines under several register settings.
    base = sent_chars;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_registers(12'hFFF, 8'hFF);
        1: set_registers(12'h000, 8'h00);
        default: set_registers(12'($urandom), 8'($urandom));
      endcase
      calm  = (ph == 2);
      lines = 0;
      while (sent_chars < base + RAND_CHARS * (ph + 1) / PHASES) begin
        send_random_line();
        lines++;
        if (lines == 6) drain();
      end
      drain();
    end
    calm = 1'b0;

    // Let the last frame words out, then give the verdict.
    rx_ch.valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("slcan_response_matcher_tb OK");
    end else begin
      $display("slcan_response_matcher_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/slcan_rm_pkg.sv
src/slcan_rm_if.sv
src/slcan_response_matcher.sv
bench/slcan_rm_checker.sv
bench/slcan_response_matcher_tb.sv
